// ----- rtl/sha_pkg.sv -----
`default_nettype none
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned LenW   = 61;
  localparam int unsigned Rounds = 64;

  typedef logic [WordW-1:0] word_t;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (WordW - n));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sha_round.sv -----
`default_nettype none
// One SHA-256 round on the working variables a..h.
module sha_round (
  input  var sha_pkg::word_t v_i   [8],
  input  var sha_pkg::word_t w_i,
  input  var sha_pkg::word_t k_i,
  output var sha_pkg::word_t v_o   [8]
);
  sha_pkg::word_t s1e, ch, s0a, maj, t1, t2;
  always_comb begin
    s1e = sha_pkg::ror(v_i[4], 6) ^ sha_pkg::ror(v_i[4], 11) ^ sha_pkg::ror(v_i[4], 25);
    ch  = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    t1  = v_i[7] + s1e + ch + k_i + w_i;
    s0a = sha_pkg::ror(v_i[0], 2) ^ sha_pkg::ror(v_i[0], 13) ^ sha_pkg::ror(v_i[0], 22);
    maj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t2  = s0a + maj;
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
  end
endmodule
`default_nettype wire

// ----- rtl/sha256_stream_hasher.sv -----
`default_nettype none
// Channel | Handshake            | Fields                                         | Flow
// in      | in_valid, in_ready   | in_data_byte, in_byte_present, in_message_end  | into block
// out     | out_valid, out_ready | out_digest_word, out_word_index, out_last_word | out of block
//
// A byte that neither completes a block nor ends the message is a single-cycle transfer, and
// in_ready stays high. A byte that completes a 64-byte block drops in_ready through the load
// state, 64 rounds and the fold state. The block memory is read one word per round.
// An end item writes the padding bytes at one per cycle (64 minus the bytes held, plus a whole
// block when the length does not fit), with compression after each padded block, then a hand-off
// that moves the digest into the output register. Synchronous reset (rst_n low) restores the
// initial chaining words and empties the output register. A stalled receiver holds the
// current digest word; the next message is taken meanwhile, but its digest waits for
// the output register before hand-off and no further input is taken until then.
module sha256_stream_hasher (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_byte_present,
  input  wire         in_message_end,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);
  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_DONE
  } state_t;

  state_t                   state_r;
  sha_pkg::word_t           chain_r [8];
  sha_pkg::word_t           v_r [8];
  sha_pkg::word_t           v_nxt [8];
  sha_pkg::word_t           win_r [16];    // rolling schedule window, oldest word first
  sha_pkg::word_t           buf_mem [16];  // message block memory, big-endian words
  sha_pkg::word_t           rd_r;          // registered read data of the block memory
  sha_pkg::word_t           wacc_r;        // word being assembled from bytes
  sha_pkg::word_t           dig_r [8];     // digest held for the output channel
  logic [5:0]               pos_r;         // bytes held in the current block
  logic [6:0]               rnd_r;
  logic [sha_pkg::LenW-1:0] len_r;
  logic [63:0]              bits_r;
  logic                     fin_r;         // an end item has been taken
  logic                     ending_r;      // the 0x80 byte is still to be written
  logic                     len_here_r;    // the length field goes into the current block
  logic                     ovalid_r;
  logic [1:0]               oidx_r;

  logic [5:0]               pos_inc;
  logic [sha_pkg::LenW-1:0] len_inc;
  assign pos_inc = pos_r + 6'd1;
  assign len_inc = len_r + 61'd1;

  // Byte write source: the input byte in IDLE, padding and length bytes in PAD.
  logic [7:0] wbyte;
  logic       wen;
  always_comb begin
    wbyte = in_data_byte;
    wen   = 1'b0;
    if (state_r == S_IDLE) begin
      wen = in_valid && in_byte_present;
    end else if (state_r == S_PAD) begin
      wen = 1'b1;
      if (ending_r) begin
        wbyte = sha_pkg::PadByte;
      end else if (len_here_r && pos_r >= sha_pkg::LenPos) begin
        // The last eight bytes carry the bit length, most significant byte first.
        wbyte = bits_r[{~pos_r[2:0], 3'b000} +: 8];
      end else begin
        wbyte = 8'h00;
      end
    end
  end

  // Word accumulator; the full word is written into memory with its fourth byte.
  sha_pkg::word_t wacc_nxt;
  always_comb begin
    wacc_nxt = wacc_r;
    wacc_nxt[{~pos_r[1:0], 3'b000} +: 8] = wbyte;
  end

  // During the rounds the memory is read one word ahead, so round r sees word r.
  // The load cycle fetches word 0. No write happens while a block is compressed.
  logic [3:0] rd_addr;
  assign rd_addr = (state_r == S_ROUND) ? rnd_r[3:0] + 4'd1 : 4'd0;

  always_ff @(posedge clk) begin
    if (wen && pos_r[1:0] == 2'd3) buf_mem[pos_r[5:2]] <= wacc_nxt;
    rd_r <= buf_mem[rd_addr];
    if (wen) wacc_r <= wacc_nxt;
  end

  // Schedule word for the current round: from memory for the first 16 rounds,
  // from the rolling window after that.
  sha_pkg::word_t w_cur, s0, s1;
  always_comb begin
    s0 = sha_pkg::ror(win_r[1], 7) ^ sha_pkg::ror(win_r[1], 18) ^ (win_r[1] >> 3);
    s1 = sha_pkg::ror(win_r[14], 17) ^ sha_pkg::ror(win_r[14], 19) ^ (win_r[14] >> 10);
    w_cur = (rnd_r < 7'd16) ? rd_r : (win_r[0] + s0 + win_r[9] + s1);
  end

  sha_pkg::word_t k_cur;
  assign k_cur = sha_pkg::K_TAB[rnd_r[5:0]];

  sha_round u_round (.v_i(v_r), .w_i(w_cur), .k_i(k_cur), .v_o(v_nxt));

  // The output register is free when empty or when its last word leaves now.
  logic out_free;
  logic hand_off;
  assign out_free = !ovalid_r || (out_ready && oidx_r == 2'd3);
  assign hand_off = (state_r == S_DONE) && out_free;

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = ovalid_r;
  assign out_digest_word = {dig_r[{oidx_r, 1'b0}], dig_r[{oidx_r, 1'b1}]};
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 8; i++) chain_r[i] <= sha_pkg::H_INIT[i];
      for (int i = 0; i < 8; i++) v_r[i] <= '0;
      pos_r <= '0; rnd_r <= '0; len_r <= '0; bits_r <= '0;
      fin_r <= 1'b0; ending_r <= 1'b0; len_here_r <= 1'b0;
      ovalid_r <= 1'b0; oidx_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_byte_present) begin
              pos_r <= pos_inc;
              len_r <= len_inc;
            end
            if (in_message_end) bits_r <= {(in_byte_present ? len_inc : len_r), 3'b000};
            fin_r    <= in_message_end;
            ending_r <= in_message_end;
            if (in_byte_present && pos_r == 6'd63) state_r <= S_LOAD;
            else if (in_message_end) state_r <= S_PAD;
          end
        end
        S_PAD: begin
          // The length fits behind the 0x80 byte only if that byte lands before byte 56.
          if (ending_r) len_here_r <= (pos_r < sha_pkg::LenPos);
          ending_r <= 1'b0;
          pos_r    <= pos_inc;
          if (pos_r == 6'd63) state_r <= S_LOAD;
        end
        S_LOAD: begin
          for (int i = 0; i < 8; i++) v_r[i] <= chain_r[i];
          rnd_r   <= '0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          v_r <= v_nxt;
          for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
          win_r[15] <= w_cur;
          rnd_r     <= rnd_r + 7'd1;
          if (rnd_r == 7'(sha_pkg::Rounds - 1)) state_r <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + v_r[i];
          rnd_r <= '0;
          if (!fin_r) begin
            state_r <= S_IDLE;
          end else if (!ending_r && len_here_r) begin
            state_r <= S_DONE;
          end else begin
            // Padding goes on: either the 0x80 byte is still due, or a block of
            // zeros that ends in the length follows.
            if (!ending_r) len_here_r <= 1'b1;
            state_r <= S_PAD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            for (int i = 0; i < 8; i++) chain_r[i] <= sha_pkg::H_INIT[i];
            len_r   <= '0;
            pos_r   <= '0;
            fin_r   <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (hand_off) begin
        for (int i = 0; i < 8; i++) dig_r[i] <= chain_r[i];
        ovalid_r <= 1'b1;
        oidx_r   <= '0;
      end else if (ovalid_r && out_ready) begin
        oidx_r <= oidx_r + 2'd1;
        if (oidx_r == 2'd3) ovalid_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sha_checker.sv -----
`default_nettype none
module sha_checker (
  input wire clk, input wire rst_n,
  input wire out_valid, input wire out_ready,
  input wire [1:0] out_word_index, input wire out_last_word
);
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 2'd3))) else $error("last flag");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=> out_valid) else $error("gap in digest");
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("valid dropped");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_word_index)) else $error("index moved");
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_word_index == 2'd0)) else $error("digest not from word 0");
endmodule
bind sha256_stream_hasher sha_checker u_chk (.*);
`default_nettype wire
